// ----- rtl/lrfd_pkg.sv -----
// ----------------------------------------------------------------------------
// lrfd_pkg
// Shared types and constants of the flag-driven LZ/RLE decompressor.
// ----------------------------------------------------------------------------
package lrfd_pkg;

  localparam int HISTORY_DEPTH_DEF = 4096;
  localparam int OUTPUT_LANES_DEF  = 4;
  localparam int MAX_LANES         = 4;
  localparam int FLAG_COMMANDS     = 4;

  localparam logic [1:0] OP_FLAG  = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_KIND     = 2'd1;
  localparam logic [1:0] ERR_DISTANCE = 2'd2;
  localparam logic [1:0] ERR_DONE     = 2'd3;

  localparam logic [1:0] CMD_LITERAL = 2'd0;
  localparam logic [1:0] CMD_LITRUN  = 2'd1;
  localparam logic [1:0] CMD_REPEAT  = 2'd2;
  localparam logic [1:0] CMD_COPY    = 2'd3;

  typedef enum logic [1:0] {
    KIND_FLAG,
    KIND_DATA,
    KIND_FRAME,
    KIND_BAD
  } kind_t;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_CMD,
    PH_LITRUN,
    PH_REPVAL,
    PH_COPYLO
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WR
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [MAX_LANES-1:0][7:0] lanes;
    logic [2:0]                count;
    logic                      want_flag;
    logic                      done;
    logic [1:0]                err;
    logic                      last;
  } res_t;

  function automatic int lanes_used(input int n);
    if (n > MAX_LANES) begin
      return MAX_LANES;
    end
    if (n < 1) begin
      return 1;
    end
    return n;
  endfunction

endpackage

// ----- rtl/lrfd_front.sv -----
// ----------------------------------------------------------------------------
// lrfd_front
// Accepts input requests, classifies their opcode and queues them.
// ----------------------------------------------------------------------------
module lrfd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     opcode,
  input  logic [7:0]     byte_value,
  output logic           q_valid,
  output lrfd_pkg::req_t q_req,
  input  logic           q_pop
);

  lrfd_pkg::req_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  lrfd_pkg::req_t classified;
  logic           push;

  always_comb begin
    classified.value = byte_value;
    case (opcode)
      lrfd_pkg::OP_FLAG:  classified.kind = lrfd_pkg::KIND_FLAG;
      lrfd_pkg::OP_DATA:  classified.kind = lrfd_pkg::KIND_DATA;
      lrfd_pkg::OP_FRAME: classified.kind = lrfd_pkg::KIND_FRAME;
      default:            classified.kind = lrfd_pkg::KIND_BAD;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_req    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- rtl/lrfd_back.sv -----
// ----------------------------------------------------------------------------
// lrfd_back
// Executes queued requests: command decoding, history memory and lane packing.
// ----------------------------------------------------------------------------
module lrfd_back #(
  parameter int HISTORY_DEPTH = lrfd_pkg::HISTORY_DEPTH_DEF,
  parameter int OUTPUT_LANES  = lrfd_pkg::OUTPUT_LANES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    output_length,
  input  logic           q_valid,
  input  lrfd_pkg::req_t q_req,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output lrfd_pkg::res_t res
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int LANES = lrfd_pkg::lanes_used(OUTPUT_LANES);

  logic [7:0] hist [HISTORY_DEPTH];
  logic [7:0] rd_data;

  lrfd_pkg::state_t state, state_next;
  lrfd_pkg::phase_t phase, phase_next;
  logic [7:0]  flag_shift, flag_shift_next;
  logic [2:0]  cmds_left, cmds_left_next;
  logic [7:0]  pending, pending_next;
  logic [7:0]  dist_high, dist_high_next;
  logic [31:0] produced, produced_next;
  logic [AW-1:0] ptr, ptr_next;
  logic        copy_mode, copy_mode_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  byte_val, byte_val_next;
  logic [11:0] copy_dist, copy_dist_next;
  logic        st_want, st_want_next;
  logic        st_done, st_done_next;
  logic [1:0]  st_err, st_err_next;
  logic [lrfd_pkg::MAX_LANES-1:0][7:0] lanes, lanes_next;
  logic [1:0]  lane_idx, lane_idx_next;
  logic        out_valid_next;
  lrfd_pkg::res_t res_next;

  logic [AW-1:0] src;
  logic          out_free;
  logic          flush;
  logic          proceed;
  logic          wr_en;
  logic [7:0]    wbyte;
  logic [31:0]   rem;

  always_comb begin
    if ({20'd0, copy_dist} <= 32'(ptr)) begin
      src = AW'(32'(ptr) - 32'(copy_dist));
    end else begin
      src = AW'(32'(ptr) + 32'(HISTORY_DEPTH) - 32'(copy_dist));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[ptr] <= wbyte;
    end
    rd_data <= hist[src];
  end

  assign out_free = !out_valid || out_ready;
  assign rem      = output_length - produced;
  assign wbyte    = copy_mode ? rd_data : byte_val;
  assign flush    = (lane_idx == 2'(LANES - 1)) || (bytes_left == 8'd1);
  assign proceed  = (state == lrfd_pkg::S_WR) && (!flush || out_free);
  assign wr_en    = proceed;

  always_comb begin
    logic        err_path;
    logic [1:0]  err;
    logic [7:0]  cnt;
    logic [7:0]  n;
    logic        fin;
    logic        emit_copy;
    logic        done_after;
    logic [2:0]  cl;
    logic [11:0] d;

    state_next      = state;
    phase_next      = phase;
    flag_shift_next = flag_shift;
    cmds_left_next  = cmds_left;
    pending_next    = pending;
    dist_high_next  = dist_high;
    produced_next   = produced;
    ptr_next        = ptr;
    copy_mode_next  = copy_mode;
    bytes_left_next = bytes_left;
    byte_val_next   = byte_val;
    copy_dist_next  = copy_dist;
    st_want_next    = st_want;
    st_done_next    = st_done;
    st_err_next     = st_err;
    lanes_next      = lanes;
    lane_idx_next   = lane_idx;
    out_valid_next  = out_valid && !out_ready;
    res_next        = res;
    q_pop           = 1'b0;
    err_path        = 1'b1;
    err             = lrfd_pkg::ERR_NONE;
    cnt             = 8'd0;
    n               = 8'd0;
    fin             = 1'b0;
    emit_copy       = 1'b0;
    done_after      = 1'b0;
    cl              = 3'd0;
    d               = {dist_high, q_req.value[7:4]};

    case (state)
      lrfd_pkg::S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_req.kind == lrfd_pkg::KIND_FRAME) begin
            flag_shift_next = 8'd0;
            cmds_left_next  = 3'd0;
            phase_next      = lrfd_pkg::PH_FLAG;
            pending_next    = 8'd0;
            dist_high_next  = 8'd0;
            produced_next   = 32'd0;
            ptr_next        = '0;
            done_after      = (output_length == 32'd0);
          end else if (q_req.kind == lrfd_pkg::KIND_BAD) begin
            err = lrfd_pkg::ERR_KIND;
          end else if (produced >= output_length) begin
            err = lrfd_pkg::ERR_DONE;
          end else if ((q_req.kind == lrfd_pkg::KIND_FLAG) != (phase == lrfd_pkg::PH_FLAG)) begin
            err = lrfd_pkg::ERR_KIND;
          end else begin
            err_path = 1'b0;
            if (q_req.kind == lrfd_pkg::KIND_FLAG) begin
              flag_shift_next = q_req.value;
              cmds_left_next  = 3'(lrfd_pkg::FLAG_COMMANDS);
              phase_next      = lrfd_pkg::PH_CMD;
            end else begin
              case (phase)
                lrfd_pkg::PH_CMD: begin
                  case (flag_shift[7:6])
                    lrfd_pkg::CMD_LITERAL: begin
                      cnt = 8'd1;
                      fin = 1'b1;
                    end
                    lrfd_pkg::CMD_LITRUN: begin
                      if (q_req.value == 8'd0) begin
                        fin = 1'b1;
                      end else begin
                        pending_next = q_req.value;
                        phase_next   = lrfd_pkg::PH_LITRUN;
                      end
                    end
                    lrfd_pkg::CMD_REPEAT: begin
                      pending_next = q_req.value;
                      phase_next   = lrfd_pkg::PH_REPVAL;
                    end
                    default: begin
                      dist_high_next = q_req.value;
                      phase_next     = lrfd_pkg::PH_COPYLO;
                    end
                  endcase
                end
                lrfd_pkg::PH_LITRUN: begin
                  cnt          = 8'd1;
                  pending_next = pending - 8'd1;
                  fin          = (pending == 8'd1);
                end
                lrfd_pkg::PH_REPVAL: begin
                  cnt          = pending;
                  pending_next = 8'd0;
                  fin          = 1'b1;
                end
                default: begin
                  fin = 1'b1;
                  if ((q_req.value[3:0] != 4'd0) &&
                      ((d == 12'd0) || ({20'd0, d} > produced))) begin
                    err = lrfd_pkg::ERR_DISTANCE;
                  end else begin
                    cnt       = {4'd0, q_req.value[3:0]};
                    emit_copy = 1'b1;
                  end
                end
              endcase
            end
            n = ({24'd0, cnt} <= rem) ? cnt : rem[7:0];
            done_after = ({24'd0, n} == rem);
            if (fin) begin
              flag_shift_next = {flag_shift[5:0], 2'b00};
              cl = (cmds_left != 3'd0) ? cmds_left - 3'd1 : 3'd0;
              cmds_left_next = cl;
              phase_next = (cl == 3'd0) ? lrfd_pkg::PH_FLAG : lrfd_pkg::PH_CMD;
            end
          end
          if (err_path && q_req.kind != lrfd_pkg::KIND_FRAME) begin
            done_after = (produced >= output_length);
          end
          st_want_next   = (phase_next == lrfd_pkg::PH_FLAG) && !done_after;
          st_done_next   = done_after;
          st_err_next    = err;
          copy_mode_next = emit_copy;
          bytes_left_next = n;
          byte_val_next  = q_req.value;
          copy_dist_next = d;
          lane_idx_next  = 2'd0;
          lanes_next     = '0;
          if (n != 8'd0) begin
            state_next = emit_copy ? lrfd_pkg::S_RD : lrfd_pkg::S_WR;
          end else begin
            out_valid_next     = 1'b1;
            res_next.lanes     = '0;
            res_next.count     = 3'd0;
            res_next.want_flag = (phase_next == lrfd_pkg::PH_FLAG) && !done_after;
            res_next.done      = done_after;
            res_next.err       = err;
            res_next.last      = 1'b1;
          end
        end
      end
      lrfd_pkg::S_RD: begin
        state_next = lrfd_pkg::S_WR;
      end
      lrfd_pkg::S_WR: begin
        if (proceed) begin
          ptr_next        = (ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr + AW'(1);
          produced_next   = produced + 32'd1;
          bytes_left_next = bytes_left - 8'd1;
          lanes_next[lane_idx] = wbyte;
          if (flush) begin
            out_valid_next     = 1'b1;
            res_next.lanes     = lanes_next;
            res_next.count     = 3'(lane_idx) + 3'd1;
            res_next.want_flag = st_want;
            res_next.done      = st_done;
            res_next.err       = st_err;
            res_next.last      = (bytes_left == 8'd1);
            lanes_next         = '0;
            lane_idx_next      = 2'd0;
          end else begin
            lane_idx_next = lane_idx + 2'd1;
          end
          if (bytes_left == 8'd1) begin
            state_next = lrfd_pkg::S_IDLE;
          end else begin
            state_next = copy_mode ? lrfd_pkg::S_RD : lrfd_pkg::S_WR;
          end
        end
      end
      default: begin
        state_next = lrfd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lrfd_pkg::S_IDLE;
      phase      <= lrfd_pkg::PH_FLAG;
      flag_shift <= 8'd0;
      cmds_left  <= 3'd0;
      pending    <= 8'd0;
      dist_high  <= 8'd0;
      produced   <= 32'd0;
      ptr        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      flag_shift <= flag_shift_next;
      cmds_left  <= cmds_left_next;
      pending    <= pending_next;
      dist_high  <= dist_high_next;
      produced   <= produced_next;
      ptr        <= ptr_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    copy_mode  <= copy_mode_next;
    bytes_left <= bytes_left_next;
    byte_val   <= byte_val_next;
    copy_dist  <= copy_dist_next;
    st_want    <= st_want_next;
    st_done    <= st_done_next;
    st_err     <= st_err_next;
    lanes      <= lanes_next;
    lane_idx   <= lane_idx_next;
    res        <= res_next;
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == lrfd_pkg::S_IDLE)
    else $error("Request taken while a command is still running.");

  a_lane_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res.count <= 3'(LANES))
    else $error("Result holds more bytes than lanes in use.");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.err != lrfd_pkg::ERR_NONE) |-> res.count == 3'd0)
    else $error("Failed request produced bytes.");

  a_done_no_want: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.done) |-> !res.want_flag)
    else $error("Finished frame still asks for a flag byte.");

endmodule

// ----- rtl/lz_rle_flag_decompressor_unit.sv -----
// ----------------------------------------------------------------------------
// lz_rle_flag_decompressor_unit
// Flag-driven LZ77 decompressor with literal runs and byte repeats.
// ----------------------------------------------------------------------------
// A request that emits no byte returns its result from the idle state. A
// repeat writes one byte per cycle unless back-pressure holds a full lane
// group; a copy passes a read and a write state per byte, as the registered
// history read must return before the byte is written. A two-entry queue
// lets new requests be accepted while a command is running.
module lz_rle_flag_decompressor_unit #(
  parameter int HISTORY_DEPTH = lrfd_pkg::HISTORY_DEPTH_DEF,
  parameter int OUTPUT_LANES  = lrfd_pkg::OUTPUT_LANES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  lane0,
  output logic [7:0]  lane1,
  output logic [7:0]  lane2,
  output logic [7:0]  lane3,
  output logic [2:0]  lane_count,
  output logic        want_flag,
  output logic        frame_done,
  output logic [1:0]  error_code,
  output logic        last
);

  logic [31:0]    output_length;
  logic           q_valid;
  lrfd_pkg::req_t q_req;
  logic           q_pop;
  lrfd_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= 32'd0;
    end else if (cfg_write) begin
      output_length <= cfg_data;
    end
  end

  lrfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .byte_value (byte_value),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop)
  );

  lrfd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .OUTPUT_LANES  (OUTPUT_LANES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .output_length (output_length),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .res           (res)
  );

  assign lane0      = res.lanes[0];
  assign lane1      = res.lanes[1];
  assign lane2      = res.lanes[2];
  assign lane3      = res.lanes[3];
  assign lane_count = res.count;
  assign want_flag  = res.want_flag;
  assign frame_done = res.done;
  assign error_code = res.err;
  assign last       = res.last;

endmodule
